/* src/irbd_pkg.sv */
// Shared types, widths, request codes and helpers of the IR blockage detector.
// Used by irbd_chan_mem, irbd_divider and ir_blockage_detector; no dependencies.
package irbd_pkg;

  localparam int CHANNELS_DEF = 12;
  localparam int CH_IDX_W     = 4;
  localparam int SMP_W        = 8;
  localparam int REQ_W        = 2;
  localparam int KIND_W       = 2;
  localparam int PCT_W        = 7;
  localparam int SUM_W        = 12;
  localparam int PROD_W       = SUM_W + PCT_W;
  localparam int DIV_W        = 32;
  localparam int DIV_CNT_W    = 6;
  localparam int CREDIT_W     = 8;
  localparam int LIMIT_W      = 7;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 8;

  localparam logic [SMP_W-1:0]    SMP_MAX        = 8'hFF;
  localparam logic [PCT_W-1:0]    PCT_MAX        = 7'd100;
  localparam logic [SMP_W-1:0]    MARGIN_RST     = 8'd5;
  localparam logic [LIMIT_W-1:0]  LIMIT_RST      = 7'd64;
  localparam logic [CREDIT_W-1:0] CREDIT_STEP    = 8'd2;
  localparam logic [DIV_CNT_W-1:0] FRAME_STEPS   = DIV_CNT_W'(PROD_W);
  localparam logic [DIV_CNT_W-1:0] AVG_STEPS     = DIV_CNT_W'(DIV_W);

  typedef enum logic [REQ_W-1:0] {
    REQ_SAMPLE   = 2'd0,
    REQ_TICK     = 2'd1,
    REQ_READ_MAX = 2'd2,
    REQ_READ_AVG = 2'd3
  } req_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_FRAME = 2'd0,
    KIND_MAX   = 2'd1,
    KIND_AVG   = 2'd2
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DETECT_MARGIN = 1'd0,
    CFG_BUDGET_LIMIT  = 1'd1
  } cfg_reg_t;

  // Request to the channel store: one read port, one write port per array
  typedef struct packed {
    logic                rd_en;
    logic [CH_IDX_W-1:0] rd_addr;
    logic                last_we;
    logic [CH_IDX_W-1:0] last_addr;
    logic [SMP_W-1:0]    last_data;
    logic                min_we;
    logic [CH_IDX_W-1:0] min_addr;
    logic [SMP_W-1:0]    min_data;
  } mem_req_t;

  typedef struct packed {
    logic [SMP_W-1:0] last;
    logic [SMP_W-1:0] min;
  } mem_rsp_t;

  // Saturate a quotient to the percent range
  function automatic logic [PCT_W-1:0] sat_pct(input logic [DIV_W-1:0] q);
    logic [PCT_W-1:0] r;
    if (q > DIV_W'(PCT_MAX)) r = PCT_MAX;
    else                     r = q[PCT_W-1:0];
    return r;
  endfunction

endpackage

/* src/irbd_chan_mem.sv */
// Per-channel last-sample and minimum stores, synchronous registered read.
// Valid bits give the reset contents (last 0, minimum 255). Depends on irbd_pkg.
module irbd_chan_mem #(
  parameter int CHANNELS = irbd_pkg::CHANNELS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  irbd_pkg::mem_req_t req,
  output irbd_pkg::mem_rsp_t rsp
);
  import irbd_pkg::*;

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [SMP_W-1:0]    last_mem [CHANNELS];
  logic [SMP_W-1:0]    min_mem  [CHANNELS];
  logic [CHANNELS-1:0] last_vld_r;
  logic [CHANNELS-1:0] min_vld_r;
  logic [SMP_W-1:0]    last_q_r;
  logic [SMP_W-1:0]    min_q_r;
  logic                last_qv_r;
  logic                min_qv_r;

  always_ff @(posedge clk) begin
    if (req.last_we) begin
      last_mem[req.last_addr[AW-1:0]] <= req.last_data;
    end
    if (req.min_we) begin
      min_mem[req.min_addr[AW-1:0]] <= req.min_data;
    end
    if (req.rd_en) begin
      last_q_r <= last_mem[req.rd_addr[AW-1:0]];
      min_q_r  <= min_mem[req.rd_addr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_vld_r <= '0;
      min_vld_r  <= '0;
      last_qv_r  <= 1'b0;
      min_qv_r   <= 1'b0;
    end else begin
      if (req.last_we) last_vld_r[req.last_addr[AW-1:0]] <= 1'b1;
      if (req.min_we)  min_vld_r[req.min_addr[AW-1:0]]   <= 1'b1;
      if (req.rd_en) begin
        last_qv_r <= last_vld_r[req.rd_addr[AW-1:0]];
        min_qv_r  <= min_vld_r[req.rd_addr[AW-1:0]];
      end
    end
  end

  // An entry never written reads as its reset value
  assign rsp.last = last_qv_r ? last_q_r : '0;
  assign rsp.min  = min_qv_r  ? min_q_r  : SMP_MAX;

endmodule

/* src/irbd_divider.sv */
// Restoring divider, one quotient bit per cycle, step count chosen per request.
// The dividend is aligned to the top; done pulses with the quotient. Depends on irbd_pkg.
module irbd_divider (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [irbd_pkg::DIV_W-1:0]     dividend,
  input  logic [irbd_pkg::DIV_W-1:0]     divisor,
  input  logic [irbd_pkg::DIV_CNT_W-1:0] steps,
  output logic                           done,
  output logic [irbd_pkg::DIV_W-1:0]     quotient
);
  import irbd_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_W-1:0]     rem_r;
  logic [DIV_W-1:0]     dvd_r;
  logic [DIV_W-1:0]     dvs_r;
  logic [DIV_W-1:0]     quo_r;
  logic [DIV_W:0]       rem_sh;
  logic [DIV_W:0]       diff;
  logic                 ge;

  assign rem_sh = {rem_r, dvd_r[DIV_W-1]};
  assign diff   = rem_sh - {1'b0, dvs_r};
  assign ge     = rem_sh >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvd_r <= dividend;
      dvs_r <= divisor;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
      dvd_r <= {dvd_r[DIV_W-2:0], 1'b0};
      quo_r <= {quo_r[DIV_W-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

/* src/ir_blockage_detector.sv */
// Top level of the IR blockage detector: request sequencer, frame statistics, result register.
// Instantiates irbd_chan_mem and irbd_divider; depends on irbd_pkg.
//
//  channel | direction | payload                                   | handshake
//  in_     | slave     | tuser: req_type[1:0]; tdata: sample[7:0]  | tvalid/tready
//  out_    | master    | tuser: result_kind[1:0]; tdata: pct[6:0]  | tvalid/tready
//  cfg_    | slave     | index: register; data: value              | valid/ready
//
// Mid-frame sample: stored with no walk. Read max: goes straight to push. Read average: runs
// the 32-step serial divider when frames were counted. Last sample of a frame: a store walk
// over all channels (one read, one write-back per channel) plus 19 divider steps, then push.
// Correction tick: credit top-up, plus a store walk when the credit is positive.
// Reset is synchronous, active low; no clearing pass (valid bits give the store reset values).
// One request at a time; a result waits in the output register, the next request is held off
// only until a new result must take its place.
module ir_blockage_detector #(
  parameter int CHANNELS = irbd_pkg::CHANNELS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [irbd_pkg::REQ_W-1:0]      in_tuser,   // [1:0] req_type
  input  logic [irbd_pkg::SMP_W-1:0]      in_tdata,   // [7:0] sample_value
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [irbd_pkg::KIND_W-1:0]     out_tuser,  // [1:0] result_kind
  output logic [7:0]                      out_tdata,  // [6:0] percent_value, [7] zero
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [irbd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [irbd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import irbd_pkg::*;

  localparam logic [CH_IDX_W-1:0] CH_LAST = CH_IDX_W'(CHANNELS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_UPD,
    S_DIV_GO,
    S_FRAME_DIV,
    S_FRAME_END,
    S_AVG_DIV,
    S_PUSH
  } state_t;

  state_t               state_r;
  logic [SMP_W-1:0]     margin_r;
  logic [LIMIT_W-1:0]   limit_r;
  logic [CH_IDX_W-1:0]  ch_idx_r;
  logic [CH_IDX_W-1:0]  walk_idx_r;
  logic                 walk_frame_r;
  logic [SUM_W-1:0]     excess_r;
  logic [SUM_W-1:0]     headroom_r;
  logic [PCT_W-1:0]     pct_max_r;
  logic [DIV_W-1:0]     pct_total_r;
  logic [DIV_W-1:0]     frame_cnt_r;
  logic [CREDIT_W-1:0]  credit_r;
  kind_t                res_kind_r;
  logic [PCT_W-1:0]     res_pct_r;
  logic                 out_valid_r;
  kind_t                out_kind_r;
  logic [PCT_W-1:0]     out_pct_r;

  mem_req_t             mreq;
  mem_rsp_t             mrsp;
  logic                 div_start;
  logic [DIV_W-1:0]     div_dvd;
  logic [DIV_W-1:0]     div_dvs;
  logic [DIV_CNT_W-1:0] div_steps;
  logic                 div_done;
  logic [DIV_W-1:0]     div_quo;

  logic                 in_acc;
  req_t                 req;
  logic [CH_IDX_W-1:0]  ch_cur;
  logic [CREDIT_W-1:0]  credit_add;
  logic                 credit_pos;
  logic [SMP_W-1:0]     min_new;
  logic [SMP_W:0]       thr_sum;
  logic [SMP_W-1:0]     thr;
  logic [SUM_W-1:0]     headroom_inc;
  logic [SUM_W-1:0]     excess_inc;
  logic                 tick_raise;
  logic [PROD_W-1:0]    prod;
  logic                 out_free;

  assign req       = req_t'(in_tuser);
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_tready;

  assign ch_cur = (int'(ch_idx_r) >= CHANNELS) ? '0 : ch_idx_r;

  // Credit after the optional top-up, compared as signed against the budget
  assign credit_add = ($signed(credit_r) < $signed({1'b0, limit_r})) ?
                      credit_r + CREDIT_STEP : credit_r;
  assign credit_pos = !credit_add[CREDIT_W-1] && (credit_add != '0);

  // Frame walk arithmetic on the entry just read
  assign min_new      = (mrsp.last < mrsp.min) ? mrsp.last : mrsp.min;
  assign thr_sum      = {1'b0, min_new} + {1'b0, margin_r};
  assign thr          = thr_sum[SMP_W] ? SMP_MAX : thr_sum[SMP_W-1:0];
  assign headroom_inc = SUM_W'(SMP_MAX - thr);
  assign excess_inc   = (mrsp.last > thr) ? SUM_W'(mrsp.last - thr) : '0;
  assign tick_raise   = mrsp.last > mrsp.min;

  assign prod = PROD_W'(excess_r) * PROD_W'(PCT_MAX);

  always_comb begin
    mreq           = '0;
    mreq.last_addr = ch_cur;
    mreq.last_data = in_tdata;
    mreq.last_we   = in_acc && (req == REQ_SAMPLE);
    mreq.rd_en     = (state_r == S_RD);
    mreq.rd_addr   = walk_idx_r;
    mreq.min_addr  = walk_idx_r;
    if (state_r == S_UPD) begin
      if (walk_frame_r) begin
        mreq.min_we   = 1'b1;
        mreq.min_data = min_new;
      end else begin
        mreq.min_we   = tick_raise;
        mreq.min_data = mrsp.min + 1'b1;
      end
    end
  end

  always_comb begin
    div_start = 1'b0;
    div_dvd   = pct_total_r;
    div_dvs   = frame_cnt_r;
    div_steps = AVG_STEPS;
    if (in_acc && (req == REQ_READ_AVG) && (frame_cnt_r != '0)) begin
      div_start = 1'b1;
    end else if ((state_r == S_DIV_GO) && (headroom_r != '0)) begin
      div_start = 1'b1;
      div_dvd   = {prod, {(DIV_W-PROD_W){1'b0}}};
      div_dvs   = DIV_W'(headroom_r);
      div_steps = FRAME_STEPS;
    end
  end

  irbd_chan_mem #(
    .CHANNELS(CHANNELS)
  ) u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .rsp   (mrsp)
  );

  irbd_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .steps    (div_steps),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      margin_r     <= MARGIN_RST;
      limit_r      <= LIMIT_RST;
      ch_idx_r     <= '0;
      walk_idx_r   <= '0;
      walk_frame_r <= 1'b0;
      excess_r     <= '0;
      headroom_r   <= '0;
      pct_max_r    <= '0;
      pct_total_r  <= '0;
      frame_cnt_r  <= '0;
      credit_r     <= '0;
      res_kind_r   <= KIND_FRAME;
      res_pct_r    <= '0;
      out_valid_r  <= 1'b0;
      out_kind_r   <= KIND_FRAME;
      out_pct_r    <= '0;
    end else begin
      // drop a taken result; the push state sets the flag itself
      if (out_valid_r && out_tready && (state_r != S_PUSH)) out_valid_r <= 1'b0;

      if (cfg_valid) begin
        unique case (cfg_reg_t'(cfg_index))
          CFG_DETECT_MARGIN: margin_r <= cfg_data;
          CFG_BUDGET_LIMIT:  limit_r  <= cfg_data[LIMIT_W-1:0];
          default: ;
        endcase
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            unique case (req)
              REQ_SAMPLE: begin
                if (ch_cur == CH_LAST) begin
                  ch_idx_r     <= '0;
                  walk_idx_r   <= '0;
                  walk_frame_r <= 1'b1;
                  excess_r     <= '0;
                  headroom_r   <= '0;
                  state_r      <= S_RD;
                end else begin
                  ch_idx_r <= ch_cur + 1'b1;
                end
              end
              REQ_TICK: begin
                credit_r <= credit_add;
                if (credit_pos) begin
                  walk_idx_r   <= '0;
                  walk_frame_r <= 1'b0;
                  state_r      <= S_RD;
                end
              end
              REQ_READ_MAX: begin
                res_kind_r <= KIND_MAX;
                res_pct_r  <= pct_max_r;
                pct_max_r  <= '0;
                state_r    <= S_PUSH;
              end
              REQ_READ_AVG: begin
                res_kind_r  <= KIND_AVG;
                res_pct_r   <= '0;
                pct_total_r <= '0;
                frame_cnt_r <= '0;
                state_r     <= (frame_cnt_r != '0) ? S_AVG_DIV : S_PUSH;
              end
              default: ;
            endcase
          end
        end
        S_RD: begin
          state_r <= S_UPD;
        end
        S_UPD: begin
          if (walk_frame_r) begin
            excess_r   <= excess_r + excess_inc;
            headroom_r <= headroom_r + headroom_inc;
          end else if (tick_raise) begin
            credit_r <= credit_r - 1'b1;
          end
          if (walk_idx_r == CH_LAST) begin
            state_r <= walk_frame_r ? S_DIV_GO : S_IDLE;
          end else begin
            walk_idx_r <= walk_idx_r + 1'b1;
            state_r    <= S_RD;
          end
        end
        S_DIV_GO: begin
          res_kind_r <= KIND_FRAME;
          res_pct_r  <= '0;
          state_r    <= (headroom_r != '0) ? S_FRAME_DIV : S_FRAME_END;
        end
        S_FRAME_DIV: begin
          if (div_done) begin
            res_pct_r <= sat_pct(div_quo);
            state_r   <= S_FRAME_END;
          end
        end
        S_FRAME_END: begin
          if (res_pct_r > pct_max_r) pct_max_r <= res_pct_r;
          pct_total_r <= pct_total_r + DIV_W'(res_pct_r);
          frame_cnt_r <= frame_cnt_r + 1'b1;
          state_r     <= S_PUSH;
        end
        S_AVG_DIV: begin
          if (div_done) begin
            res_pct_r <= sat_pct(div_quo);
            state_r   <= S_PUSH;
          end
        end
        S_PUSH: begin
          // hold until the output register can take the result
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_kind_r  <= res_kind_r;
            out_pct_r   <= res_pct_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {1'b0, out_pct_r};

`ifndef SYNTHESIS
  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[PCT_W-1:0] <= PCT_MAX))
    else $error("result percentage above 100");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == KIND_FRAME || out_tuser == KIND_MAX || out_tuser == KIND_AVG))
    else $error("result kind out of range");

  a_walk_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD || state_r == S_UPD) |-> (walk_idx_r <= CH_LAST))
    else $error("store walk beyond last channel");

  a_no_mem_clash: assert property (@(posedge clk) disable iff (!rst_n)
    mreq.rd_en |-> !mreq.min_we && !mreq.last_we)
    else $error("store read overlaps a write");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("pending result changed before it was taken");
`endif

endmodule
